[hw/rtl/tmsf_pkg.sv]
// Shared constants, command/status types and helpers for the trimmed-mean filter.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package tmsf_pkg;

    // sizing
    localparam int MAX_WINDOW  = 64;
    localparam int SAMPLE_BITS = 12;
    localparam int IN_W        = 12;                            // sample field width
    localparam int OUT_W       = 12;                            // result field width
    localparam int WLEN_W      = 7;                             // window length register
    localparam int CNT_W       = $clog2(MAX_WINDOW + 1);        // holds MAX_WINDOW itself
    localparam int SUM_W       = SAMPLE_BITS + $clog2(MAX_WINDOW);
    localparam int DIV_W       = $clog2(MAX_WINDOW);            // divisor, up to MAX_WINDOW-2
    localparam int STEP_W      = $clog2(SUM_W + 1);             // divider step counter

    // register map
    localparam int  PADDR_W     = 2;
    localparam logic [PADDR_W-1:0] ADDR_WLEN = PADDR_W'(0);
    localparam logic [WLEN_W-1:0]  WLEN_RESET = WLEN_W'(10);

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch incoming sample word
        logic accum;     // fold latched sample into sum/min/max
        logic load;      // start divide, clear window accumulators
        logic div_step;  // one restoring-divide step
        logic out_load;  // move quotient into output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic last;      // sample being folded closes the window
        logic div_last;  // current divide step is the final one
        logic out_free;  // output register can take a new word
    } t_sts;

    // window length clamped to 3..MAX_WINDOW
    function automatic logic [CNT_W-1:0] eff_length(input logic [WLEN_W-1:0] wl);
        logic [CNT_W-1:0] n;
        if (int'(wl) < 3) begin
            n = CNT_W'(3);
        end else if (int'(wl) > MAX_WINDOW) begin
            n = CNT_W'(MAX_WINDOW);
        end else begin
            n = CNT_W'(wl);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/trimmed_mean_sample_filter_unit.sv]
// Trimmed-mean filter top: APB window-length register, tmsf_ctrl and tmsf_dp (tmsf_pkg).
// A word that does not close a window is accepted and then accumulated. A closing word then
// also runs load, the bit-serial divide and the output stage, where its mean is loaded into
// the output register. An output register parts input and output: the next window's words
// are taken while a mean waits; the next close stalls until it is taken.
// Synchronous active-low reset: window length 10, accumulators cleared, no mean pending.
`default_nettype none

module trimmed_mean_sample_filter_unit (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    // sample channel
    input  wire                            i_sample_valid,
    output logic                           o_sample_ready,
    input  wire  [tmsf_pkg::IN_W-1:0]      i_sample,
    // result channel
    output logic                           o_trimmed_mean_valid,
    input  wire                            i_trimmed_mean_ready,
    output logic [tmsf_pkg::OUT_W-1:0]     o_trimmed_mean,
    // configuration
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire  [tmsf_pkg::PADDR_W-1:0]   paddr,
    input  wire  [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    logic [tmsf_pkg::WLEN_W-1:0] r_wlen;
    tmsf_pkg::t_cmd              w_cmd;
    tmsf_pkg::t_sts              w_sts;

    // window length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen <= tmsf_pkg::WLEN_RESET;
        end else if (psel && penable && pwrite && (paddr == tmsf_pkg::ADDR_WLEN)) begin
            r_wlen <= pwdata[tmsf_pkg::WLEN_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == tmsf_pkg::ADDR_WLEN) ? {(32 - tmsf_pkg::WLEN_W)'(0), r_wlen}
                                                   : 32'd0;

    tmsf_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (i_sample_valid),
        .o_sample_ready (o_sample_ready),
        .i_sts          (w_sts),
        .o_cmd          (w_cmd)
    );

    tmsf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample    (i_sample),
        .i_wlen      (r_wlen),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_ready (i_trimmed_mean_ready),
        .o_out_valid (o_trimmed_mean_valid),
        .o_out       (o_trimmed_mean)
    );

endmodule

`default_nettype wire

[hw/rtl/tmsf_ctrl.sv]
// Sequencing state machine for the trimmed-mean filter.
// Depends on tmsf_pkg (t_cmd, t_sts); drives tmsf_dp through commands.
`default_nettype none

module tmsf_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_sample_valid,
    output logic             o_sample_ready,
    input  tmsf_pkg::t_sts   i_sts,
    output tmsf_pkg::t_cmd   o_cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ACC  = 3'd1;
    localparam logic [2:0] ST_LOAD = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_sample_valid) n_state = ST_ACC;
            ST_ACC:  n_state = i_sts.last ? ST_LOAD : ST_IDLE;
            ST_LOAD: n_state = ST_DIV;
            ST_DIV:  if (i_sts.div_last) n_state = ST_OUT;
            ST_OUT:  if (i_sts.out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // commands
    always_comb begin
        o_cmd          = '0;
        o_sample_ready = (r_state == ST_IDLE);
        o_cmd.capture  = (r_state == ST_IDLE) && i_sample_valid;
        o_cmd.accum    = (r_state == ST_ACC);
        o_cmd.load     = (r_state == ST_LOAD);
        o_cmd.div_step = (r_state == ST_DIV);
        o_cmd.out_load = (r_state == ST_OUT) && i_sts.out_free;
    end

    // a window close always runs the full divide before the output stage
    a_load_to_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD) |=> (r_state == ST_DIV))
        else $error("load not followed by divide");

    a_out_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |-> ($past(r_state) == ST_DIV || $past(r_state) == ST_OUT))
        else $error("output stage entered without divide");

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (r_state == ST_ACC))
        else $error("accepted word not accumulated");

endmodule

`default_nettype wire

[hw/rtl/tmsf_dp.sv]
// Datapath: window accumulators, restoring serial divider and output register.
// Depends on tmsf_pkg; steered by tmsf_ctrl commands.
`default_nettype none

module tmsf_dp (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire  [tmsf_pkg::IN_W-1:0]          i_sample,
    input  wire  [tmsf_pkg::WLEN_W-1:0]        i_wlen,
    input  tmsf_pkg::t_cmd                     i_cmd,
    output tmsf_pkg::t_sts                     o_sts,
    input  wire                                i_out_ready,
    output logic                               o_out_valid,
    output logic [tmsf_pkg::OUT_W-1:0]         o_out
);

    localparam int SB = tmsf_pkg::SAMPLE_BITS;
    localparam int CW = tmsf_pkg::CNT_W;
    localparam int SW = tmsf_pkg::SUM_W;
    localparam int DW = tmsf_pkg::DIV_W;
    localparam int TW = tmsf_pkg::STEP_W;

    logic [SB-1:0] r_sample;
    logic [CW-1:0] r_count;
    logic [SW-1:0] r_sum;
    logic [SB-1:0] r_min;
    logic [SB-1:0] r_max;
    logic [DW-1:0] r_divisor;
    logic [DW-1:0] r_rem;
    logic [SW-1:0] r_quo;
    logic [TW-1:0] r_step;
    logic          r_out_valid;
    logic [tmsf_pkg::OUT_W-1:0] r_out;

    logic [CW-1:0] n_len;
    logic [CW:0]   n_count_inc;
    logic [DW:0]   n_shift;
    logic          n_fits;

    assign n_len       = tmsf_pkg::eff_length(i_wlen);
    assign n_count_inc = {1'b0, r_count} + (CW+1)'(1);
    assign n_shift     = {r_rem, r_quo[SW-1]};
    assign n_fits      = (n_shift >= {1'b0, r_divisor});

    // capture incoming word
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sample <= i_sample[SB-1:0];
        end
    end

    // window accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load) begin
            r_count <= '0;
            r_sum   <= '0;
            r_min   <= '1;
            r_max   <= '0;
        end else if (i_cmd.accum) begin
            r_count <= n_count_inc[CW-1:0];
            r_sum   <= r_sum + SW'(r_sample);
            if (r_sample < r_min) r_min <= r_sample;
            if (r_sample > r_max) r_max <= r_sample;
        end
    end

    // restoring divider, one quotient bit per step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (i_cmd.load) begin
            r_quo     <= r_sum - SW'(r_min) - SW'(r_max);
            r_divisor <= DW'(n_len - CW'(2));
            r_rem     <= '0;
            r_step    <= TW'(SW);
        end else if (i_cmd.div_step) begin
            r_rem  <= n_fits ? DW'(n_shift - {1'b0, r_divisor}) : n_shift[DW-1:0];
            r_quo  <= {r_quo[SW-2:0], n_fits};
            r_step <= r_step - TW'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= r_quo[tmsf_pkg::OUT_W-1:0];
        end
    end

    // status
    assign o_sts.last     = (n_count_inc >= {1'b0, n_len});
    assign o_sts.div_last = (r_step == TW'(1));
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out          = r_out;

    a_step_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> (r_step == TW'(SW)))
        else $error("divider step count not loaded");

    a_min_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> (r_min <= r_max))
        else $error("running min above running max");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= tmsf_pkg::MAX_WINDOW)
        else $error("sample count beyond window limit");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_out)))
        else $error("pending result word lost");

endmodule

`default_nettype wire
